>>> design/quadratic_bezier_segment_generator_macros.svh
// Assertion macros shared by the checker of the quadratic Bezier segment generator
`ifndef QUADRATIC_BEZIER_SEGMENT_GENERATOR_MACROS_SVH
`define QUADRATIC_BEZIER_SEGMENT_GENERATOR_MACROS_SVH

// Consequent checked in the same cycle as the antecedent
`define QBZ_ASSERT_SAME(label, ck, rst, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rst) (ante) |-> (cons)) \
        else $error("qbz check failed");

// Consequent checked in the cycle after the antecedent
`define QBZ_ASSERT_NEXT(label, ck, rst, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rst) (ante) |=> (cons)) \
        else $error("qbz check failed");

`endif

>>> design/qbz_pkg.sv
// Shared types and constants of the quadratic Bezier segment generator
`timescale 1ns / 1ps

package qbz_pkg;

    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;

    typedef logic signed [COORD_W-1:0] coord_t;

    // One curve: start, control and end point
    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t control_x;
        coord_t control_y;
        coord_t end_x;
        coord_t end_y;
    } curve_t;

    // Control that travels down the pipeline beside the coordinates
    typedef struct packed {
        logic   first;
        logic   last;
        coord_t start_x;
        coord_t start_y;
    } side_t;

endpackage

>>> design/qbz_curve_if.sv
// Request channel carrying one quadratic Bezier curve
`timescale 1ns / 1ps

interface qbz_curve_if;
    logic           valid;
    logic           ready;
    qbz_pkg::coord_t start_x;
    qbz_pkg::coord_t start_y;
    qbz_pkg::coord_t control_x;
    qbz_pkg::coord_t control_y;
    qbz_pkg::coord_t end_x;
    qbz_pkg::coord_t end_y;

    modport source (
        output valid, start_x, start_y, control_x, control_y, end_x, end_y,
        input  ready
    );
    modport sink (
        input  valid, start_x, start_y, control_x, control_y, end_x, end_y,
        output ready
    );
endinterface

>>> design/qbz_seg_if.sv
// Request channel carrying one line segment of the polyline
`timescale 1ns / 1ps

interface qbz_seg_if;
    logic           valid;
    logic           ready;
    qbz_pkg::coord_t from_x;
    qbz_pkg::coord_t from_y;
    qbz_pkg::coord_t to_x;
    qbz_pkg::coord_t to_y;
    logic           last;

    modport source (
        output valid, from_x, from_y, to_x, to_y, last,
        input  ready
    );
    modport sink (
        input  valid, from_x, from_y, to_x, to_y, last,
        output ready
    );
endinterface

>>> design/qbz_lerp.sv
// Two-stage fixed-point lerp: a + floor((b - a) * k / 2^SHIFT)
`timescale 1ns / 1ps

module qbz_lerp #(
    parameter int KW    = 6,
    parameter int SHIFT = 5
) (
    input  logic              clk,
    input  logic              en,
    input  qbz_pkg::coord_t   a,
    input  qbz_pkg::coord_t   b,
    input  logic [KW-1:0]     k,
    output qbz_pkg::coord_t   res
);

    localparam int PW = qbz_pkg::DIFF_W + KW + 1;

    qbz_pkg::coord_t                    a_reg;
    logic signed [qbz_pkg::DIFF_W-1:0]  diff_reg;
    logic [KW-1:0]                      k_reg;
    qbz_pkg::coord_t                    res_reg;
    qbz_pkg::coord_t                    res_next;
    logic signed [PW-1:0]               prod;
    logic signed [PW-1:0]               step;

    // Stage B: scale the difference, floor-shift, add the base
    always_comb
    begin
        prod     = PW'(diff_reg) * $signed({1'b0, k_reg});
        step     = prod >>> SHIFT;
        res_next = a_reg + qbz_pkg::coord_t'(step);
    end

    // Stage A captures base and difference, stage B the result
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= a;
            diff_reg <= $signed({b[qbz_pkg::COORD_W-1], b})
                      - $signed({a[qbz_pkg::COORD_W-1], a});
            k_reg    <= k;
            res_reg  <= res_next;
        end
    end

    assign res = res_reg;

endmodule

>>> design/qbz_seq.sv
// Step sequencer: holds a curve and issues k = 1..SEGMENTS, one per cycle while en is high
`timescale 1ns / 1ps

module qbz_seq #(
    parameter int SEGMENTS = 32,
    parameter int KW       = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    qbz_curve_if.sink         curve,
    output logic              issue_valid,
    output logic [KW-1:0]     k,
    output qbz_pkg::curve_t   pts,
    output qbz_pkg::side_t    side
);

    localparam logic [KW-1:0] K_LAST = KW'(SEGMENTS);

    logic              active_reg;
    logic              active_next;
    logic [KW-1:0]     k_reg;
    logic [KW-1:0]     k_next;
    qbz_pkg::curve_t   pts_reg;
    logic              at_last;
    logic              take;

    assign at_last     = (k_reg == K_LAST);
    // A new curve may enter while the previous one issues its final step
    assign curve.ready = en && (!active_reg || at_last);
    assign take        = curve.valid && curve.ready;

    // Step counter
    always_comb
    begin
        active_next = active_reg;
        k_next      = k_reg;
        if (take)
        begin
            active_next = 1'b1;
            k_next      = KW'(1);
        end
        else if (en && active_reg)
        begin
            if (at_last)
                active_next = 1'b0;
            else
                k_next = k_reg + KW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            k_reg      <= '0;
        end
        else
        begin
            active_reg <= active_next;
            k_reg      <= k_next;
        end
    end

    // Curve points, held for the whole curve
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pts_reg.start_x   <= curve.start_x;
            pts_reg.start_y   <= curve.start_y;
            pts_reg.control_x <= curve.control_x;
            pts_reg.control_y <= curve.control_y;
            pts_reg.end_x     <= curve.end_x;
            pts_reg.end_y     <= curve.end_y;
        end
    end

    assign issue_valid  = active_reg;
    assign k            = k_reg;
    assign pts          = pts_reg;
    assign side.first   = (k_reg == KW'(1));
    assign side.last    = at_last;
    assign side.start_x = pts_reg.start_x;
    assign side.start_y = pts_reg.start_y;

endmodule

>>> design/quadratic_bezier_segment_generator.sv
// Top level of the quadratic Bezier segment generator
//
// Channels: curve (sink) takes one request per curve: start, control and end
// point in signed Q12.4. seg (source) gives SEGMENTS requests per curve, the
// polyline segments at t = k/SEGMENTS for k = 1..SEGMENTS; from of the first
// segment is the start point, to of the last is the end point, and last is
// set on the final one. SEGMENTS must be a power of two from 2 to 64.
// Throughput: while seg.ready stays high, one segment per cycle; the step
// sequencer issues one k per cycle and the next curve is taken while
// the final step of the current one issues, so curves run back to back.
// After a curve is accepted its first segment passes the sequencer registers,
// two lerp levels of two stages each, then the output register, onto seg.
// Reset clears the sequencer and all valid bits; no request is in flight.
// While a segment waits on seg.ready, the whole pipeline holds with the
// output register, curve.ready drops, and nothing is lost or repeated.
`timescale 1ns / 1ps

module quadratic_bezier_segment_generator #(
    parameter int SEGMENTS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    qbz_curve_if.sink curve,
    qbz_seg_if.source seg
);

    localparam int SHIFT = $clog2(SEGMENTS);
    localparam int KW    = SHIFT + 1;

    logic              en;
    logic              issue_valid;
    logic [KW-1:0]     issue_k;
    qbz_pkg::curve_t   pts;
    qbz_pkg::side_t    issue_side;

    logic              v_reg    [1:4];
    qbz_pkg::side_t    side_reg [1:4];
    logic [KW-1:0]     k_reg    [1:2];

    qbz_pkg::coord_t   q1x, q2x, q1y, q2y, ptx, pty;

    logic              valid_reg;
    qbz_pkg::coord_t   from_x_reg, from_y_reg, to_x_reg, to_y_reg;
    logic              last_reg;
    qbz_pkg::coord_t   prev_x_reg, prev_y_reg;

    // Whole pipeline advances when the output register is free or drains
    assign en = !valid_reg || seg.ready;

    qbz_seq #(.SEGMENTS(SEGMENTS), .KW(KW)) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .curve       (curve),
        .issue_valid (issue_valid),
        .k           (issue_k),
        .pts         (pts),
        .side        (issue_side)
    );

    // First lerp level: start-control and control-end
    qbz_lerp #(.KW(KW), .SHIFT(SHIFT)) u_l1x_a (
        .clk(clk), .en(en), .a(pts.start_x), .b(pts.control_x), .k(issue_k), .res(q1x)
    );
    qbz_lerp #(.KW(KW), .SHIFT(SHIFT)) u_l1x_b (
        .clk(clk), .en(en), .a(pts.control_x), .b(pts.end_x), .k(issue_k), .res(q2x)
    );
    qbz_lerp #(.KW(KW), .SHIFT(SHIFT)) u_l1y_a (
        .clk(clk), .en(en), .a(pts.start_y), .b(pts.control_y), .k(issue_k), .res(q1y)
    );
    qbz_lerp #(.KW(KW), .SHIFT(SHIFT)) u_l1y_b (
        .clk(clk), .en(en), .a(pts.control_y), .b(pts.end_y), .k(issue_k), .res(q2y)
    );

    // Second lerp level gives the curve point
    qbz_lerp #(.KW(KW), .SHIFT(SHIFT)) u_l2x (
        .clk(clk), .en(en), .a(q1x), .b(q2x), .k(k_reg[2]), .res(ptx)
    );
    qbz_lerp #(.KW(KW), .SHIFT(SHIFT)) u_l2y (
        .clk(clk), .en(en), .a(q1y), .b(q2y), .k(k_reg[2]), .res(pty)
    );

    // Valid bits along the lerp stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= 4; i++)
                v_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[1] <= issue_valid;
            for (int i = 2; i <= 4; i++)
                v_reg[i] <= v_reg[i-1];
        end
    end

    // Side data and step index along the lerp stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[1] <= issue_side;
            for (int i = 2; i <= 4; i++)
                side_reg[i] <= side_reg[i-1];
            k_reg[1] <= issue_k;
            k_reg[2] <= k_reg[1];
        end
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= v_reg[4];
    end

    // Output payload; the previous point becomes the next segment's from
    always_ff @(posedge clk)
    begin
        if (en && v_reg[4])
        begin
            from_x_reg <= side_reg[4].first ? side_reg[4].start_x : prev_x_reg;
            from_y_reg <= side_reg[4].first ? side_reg[4].start_y : prev_y_reg;
            to_x_reg   <= ptx;
            to_y_reg   <= pty;
            last_reg   <= side_reg[4].last;
            prev_x_reg <= ptx;
            prev_y_reg <= pty;
        end
    end

    assign seg.valid  = valid_reg;
    assign seg.from_x = from_x_reg;
    assign seg.from_y = from_y_reg;
    assign seg.to_x   = to_x_reg;
    assign seg.to_y   = to_y_reg;
    assign seg.last   = last_reg;

endmodule

>>> design/qbz_checker.sv
// Port checker of the quadratic Bezier segment generator, with its bind
`timescale 1ns / 1ps

`include "quadratic_bezier_segment_generator_macros.svh"

module qbz_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] out_to_x,
    input logic [15:0] out_to_y,
    input logic        out_last
);

    // A stalled segment stays offered
    `QBZ_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && !out_ready, out_valid)

    // A stalled segment keeps its end point and flag
    `QBZ_ASSERT_NEXT(a_hold_data, clk, rst_n, out_valid && !out_ready, $stable(out_to_x) && $stable(out_to_y) && $stable(out_last))

    // No curve is taken while the output is stalled
    `QBZ_ASSERT_SAME(a_no_take_in_stall, clk, rst_n, in_valid && in_ready, !(out_valid && !out_ready))

    // Every curve has at least two segments, so two last flags never follow
    `QBZ_ASSERT_NEXT(a_last_spacing, clk, rst_n, out_valid && out_ready && out_last, !(out_valid && out_last))

endmodule

bind quadratic_bezier_segment_generator qbz_checker u_qbz_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (curve.valid),
    .in_ready  (curve.ready),
    .out_valid (seg.valid),
    .out_ready (seg.ready),
    .out_to_x  (seg.to_x),
    .out_to_y  (seg.to_y),
    .out_last  (seg.last)
);

>>> test/tb.sv
// Self-checking testbench for the quadratic Bezier segment generator
`timescale 1ns / 1ps

module tb;

    localparam int SEGMENTS     = 32;
    localparam int SEG_SHIFT    = $clog2(SEGMENTS);
    localparam int RANDOM_ITEMS = 460;
    localparam int DRAIN_CYCLES = 40;
    localparam int QUIET_LIMIT  = 2000;
    localparam int REPORT_MAX   = 10;
    localparam int COORD_MIN    = -32768;
    localparam int COORD_MAX    = 32767;

    // How the coordinates of a random curve are drawn
    typedef enum int {
        MIX_WIDE,
        MIX_TINY,
        MIX_EDGE,
        MIX_CLUSTER
    } coord_mix_e;

    typedef struct packed {
        qbz_pkg::coord_t from_x;
        qbz_pkg::coord_t from_y;
        qbz_pkg::coord_t to_x;
        qbz_pkg::coord_t to_y;
        logic            last;
    } segment_t;

    logic clk;
    logic rst_n;

    qbz_curve_if curve_ch();
    qbz_seg_if   seg_ch();

    quadratic_bezier_segment_generator #(
        .SEGMENTS(SEGMENTS)
    ) i_dut (
        .clk  (clk),
        .rst_n(rst_n),
        .curve(curve_ch),
        .seg  (seg_ch)
    );

    qbz_pkg::curve_t pending_curves[$];
    segment_t        expected_segments[$];
    qbz_pkg::curve_t curve_held;

    int  curves_total;
    int  curves_taken;
    int  segments_seen;
    int  mismatches;
    int  quiet_cycles;
    int  send_wait;
    int  take_wait;
    bit  send_calm;
    bit  take_calm;

    always #5 clk = ~clk;

    // One lerp step: a + floor((b - a) * k / SEGMENTS)
    function automatic int lerp_step(int a, int b, int k);
        int prod;
        prod = (b - a) * k;
        return a + (prod >>> SEG_SHIFT);
    endfunction

    // Curve point at t = k / SEGMENTS, one axis
    function automatic int curve_point(int p0, int pc, int p2, int k);
        int q1;
        int q2;
        q1 = lerp_step(p0, pc, k);
        q2 = lerp_step(pc, p2, k);
        return lerp_step(q1, q2, k);
    endfunction

    // Expand one curve into its polyline segments
    function automatic void plot_curve(qbz_pkg::curve_t c);
        int px;
        int py;
        int nx;
        int ny;
        segment_t s;
        px = $signed(c.start_x);
        py = $signed(c.start_y);
        for (int k = 1; k <= SEGMENTS; k++) begin
            nx = curve_point($signed(c.start_x), $signed(c.control_x), $signed(c.end_x), k);
            ny = curve_point($signed(c.start_y), $signed(c.control_y), $signed(c.end_y), k);
            s.from_x = qbz_pkg::coord_t'(px);
            s.from_y = qbz_pkg::coord_t'(py);
            s.to_x   = qbz_pkg::coord_t'(nx);
            s.to_y   = qbz_pkg::coord_t'(ny);
            s.last   = (k == SEGMENTS);
            expected_segments.push_back(s);
            px = nx;
            py = ny;
        end
    endfunction

    function automatic void push_curve(int sx, int sy, int cx, int cy, int ex, int ey);
        qbz_pkg::curve_t c;
        c.start_x   = qbz_pkg::coord_t'(sx);
        c.start_y   = qbz_pkg::coord_t'(sy);
        c.control_x = qbz_pkg::coord_t'(cx);
        c.control_y = qbz_pkg::coord_t'(cy);
        c.end_x     = qbz_pkg::coord_t'(ex);
        c.end_y     = qbz_pkg::coord_t'(ey);
        pending_curves.push_back(c);
    endfunction

    function automatic qbz_pkg::coord_t pick_coord(coord_mix_e mix, int base);
        case (mix)
            MIX_WIDE: return qbz_pkg::coord_t'($urandom);
            MIX_TINY: return qbz_pkg::coord_t'(int'($urandom_range(0, 127)) - 64);
            MIX_EDGE:
                case ($urandom_range(0, 3))
                    0: return qbz_pkg::coord_t'(COORD_MIN);
                    1: return qbz_pkg::coord_t'(COORD_MAX);
                    2: return qbz_pkg::coord_t'(COORD_MIN + int'($urandom_range(0, 15)));
                    default: return qbz_pkg::coord_t'(COORD_MAX - int'($urandom_range(0, 15)));
                endcase
            default: return qbz_pkg::coord_t'(base + int'($urandom_range(0, 255)) - 128);
        endcase
    endfunction

    function automatic void push_random_curve();
        coord_mix_e mix;
        int base_x;
        int base_y;
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            mix = MIX_WIDE;
        else if (r < 7)
            mix = MIX_TINY;
        else if (r < 9)
            mix = MIX_EDGE;
        else
            mix = MIX_CLUSTER;
        base_x = $signed(qbz_pkg::coord_t'($urandom));
        base_y = $signed(qbz_pkg::coord_t'($urandom));
        push_curve(pick_coord(mix, base_x), pick_coord(mix, base_y),
                   pick_coord(mix, base_x), pick_coord(mix, base_y),
                   pick_coord(mix, base_x), pick_coord(mix, base_y));
    endfunction

    function automatic void check_field(string label, int want, int got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("segment %0d %s: expected %0d, got %0d",
                         segments_seen, label, want, got);
        end
    endfunction

    // Compare one output request with the oldest expectation
    function automatic void check_segment();
        segment_t want;
        if (expected_segments.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("segment %0d: unexpected request from (%0d,%0d) to (%0d,%0d)",
                         segments_seen, $signed(seg_ch.from_x), $signed(seg_ch.from_y),
                         $signed(seg_ch.to_x), $signed(seg_ch.to_y));
        end else begin
            want = expected_segments.pop_front();
            check_field("from_x", $signed(want.from_x), $signed(seg_ch.from_x));
            check_field("from_y", $signed(want.from_y), $signed(seg_ch.from_y));
            check_field("to_x", $signed(want.to_x), $signed(seg_ch.to_x));
            check_field("to_y", $signed(want.to_y), $signed(seg_ch.to_y));
            check_field("last", want.last, seg_ch.last);
        end
        segments_seen++;
    endfunction

    // Curve driver: presents queued curves, random gap after each request
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            curve_ch.valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (curve_ch.valid && curve_ch.ready) begin
                plot_curve(curve_held);
                curves_taken++;
                if ($urandom_range(0, 23) == 0)
                    send_calm = !send_calm;
                send_wait = send_calm ? 0 : $urandom_range(0, 15);
            end
            if (!curve_ch.valid || curve_ch.ready) begin
                if (send_wait == 0 && pending_curves.size() != 0) begin
                    curve_held = pending_curves.pop_front();
                    curve_ch.valid     <= 1'b1;
                    curve_ch.start_x   <= curve_held.start_x;
                    curve_ch.start_y   <= curve_held.start_y;
                    curve_ch.control_x <= curve_held.control_x;
                    curve_ch.control_y <= curve_held.control_y;
                    curve_ch.end_x     <= curve_held.end_x;
                    curve_ch.end_y     <= curve_held.end_y;
                end else begin
                    curve_ch.valid <= 1'b0;
                    if (send_wait > 0)
                        send_wait--;
                end
            end
        end
    end

    // Segment monitor: checks each request, random stall after each one
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seg_ch.ready <= 1'b0;
            take_wait = 0;
        end else begin
            if (seg_ch.valid && seg_ch.ready) begin
                check_segment();
                if ($urandom_range(0, 47) == 0)
                    take_calm = !take_calm;
                take_wait = take_calm ? 0 : $urandom_range(0, 15);
            end
            if (take_wait > 0) begin
                seg_ch.ready <= 1'b0;
                take_wait--;
            end else begin
                seg_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without any request moving on either channel
    always @(posedge clk) begin
        if (!rst_n || (curve_ch.valid && curve_ch.ready) || (seg_ch.valid && seg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clk                = 1'b0;
        rst_n              = 1'b0;
        curve_ch.valid     = 1'b0;
        curve_ch.start_x   = '0;
        curve_ch.start_y   = '0;
        curve_ch.control_x = '0;
        curve_ch.control_y = '0;
        curve_ch.end_x     = '0;
        curve_ch.end_y     = '0;
        seg_ch.ready       = 1'b0;
        curves_taken       = 0;
        segments_seen      = 0;
        mismatches         = 0;
        quiet_cycles       = 0;
        send_wait          = 0;
        take_wait          = 0;
        send_calm          = 1'b0;
        take_calm          = 1'b0;

        // Directed curves: extremes, degenerate shapes, rounding near zero
        push_curve(0, 0, 0, 0, 0, 0);
        push_curve(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        push_curve(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        push_curve(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        push_curve(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        push_curve(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        push_curve(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        push_curve(COORD_MIN, COORD_MAX, 0, 0, COORD_MAX, COORD_MIN);
        push_curve(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
        push_curve(0, 0, COORD_MAX, COORD_MIN, 0, 0);
        push_curve(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN);
        push_curve(0, 0, -1, 1, 1, -1);
        push_curve(-1, -1, 0, 0, -1, -1);
        push_curve(1, -1, COORD_MIN, COORD_MAX, -1, 1);
        push_curve(5, -7, 3, -2, -9, 11);
        push_curve(21845, -21846, -21846, 21845, 21845, -21846);
        // control on the start point, then on the end point
        push_curve(-1200, 340, -1200, 340, 9000, -4500);
        push_curve(-1200, 340, 9000, -4500, 9000, -4500);
        // straight line with the control at its middle
        push_curve(-16000, 8000, 0, 0, 16000, -8000);

        for (int i = 0; i < RANDOM_ITEMS; i++)
            push_random_curve();
        curves_total = pending_curves.size();

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (curves_taken != curves_total)
            @(posedge clk);
        while (expected_segments.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_segments.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+design
design/qbz_pkg.sv
design/qbz_curve_if.sv
design/qbz_seg_if.sv
design/qbz_lerp.sv
design/qbz_seq.sv
design/quadratic_bezier_segment_generator.sv
design/qbz_checker.sv
test/tb.sv
